// ----- rtl/tgme_pkg.sv -----
// Shared types and constants for the touch gesture to mouse event unit.
// No dependencies; every other file imports this package.
`default_nettype none

package tgme_pkg;

  localparam int RelW   = 16;
  localparam int CfgW   = 8;
  localparam int ProdW  = 25;          // 16-bit signed motion times 9-bit positive gain
  localparam int AccW   = 26;          // accumulators, 7 fraction bits
  localparam int FracW  = 7;
  localparam int MaxEv  = 3;
  localparam int CntW   = 2;

  localparam logic [CfgW-1:0] SensReset = 8'd128;
  localparam logic [CfgW-1:0] ThrReset  = 8'd1;

  // register indexes (paddr[2])
  localparam logic RegSens = 1'b0;
  localparam logic RegThr  = 1'b1;

  // command codes
  localparam logic CmdReport = 1'b0;
  localparam logic CmdLift   = 1'b1;

  // gesture codes
  localparam logic [1:0] GestNone  = 2'd0;
  localparam logic [1:0] GestTap   = 2'd1;
  localparam logic [1:0] GestHold  = 2'd2;
  localparam logic [1:0] GestOther = 2'd3;

  typedef enum logic [1:0] {
    EV_PRESS   = 2'd0,
    EV_RELEASE = 2'd1,
    EV_MOVE    = 2'd2
  } ev_kind_t;

  // one accepted word after the gain multiply
  typedef struct packed {
    logic                    command;
    logic [1:0]              gesture;
    logic                    motion;   // one finger and nonzero motion
    logic signed [ProdW-1:0] px;
    logic signed [ProdW-1:0] py;
  } scaled_t;

  // events caused by one word
  typedef struct packed {
    logic [CntW-1:0]        cnt;
    ev_kind_t [MaxEv-1:0]   kind;
    logic signed [RelW-1:0] mx;
    logic signed [RelW-1:0] my;
  } ev_group_t;

endpackage

`default_nettype wire

// ----- rtl/tgme_cfg.sv -----
// APB register file: sensitivity and move threshold.
// Depends on tgme_pkg.
`default_nettype none

module tgme_cfg
  import tgme_pkg::*;
(
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            psel,
  input  wire logic            penable,
  input  wire logic            pwrite,
  input  wire logic [2:0]      paddr,
  input  wire logic [31:0]     pwdata,
  output logic      [31:0]     prdata,
  output logic                 pready,
  output logic      [CfgW-1:0] sensitivity,
  output logic      [CfgW-1:0] move_threshold
);

  logic wr;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      sensitivity    <= SensReset;
      move_threshold <= ThrReset;
    end else if (wr) begin
      case (paddr[2])
        RegSens: sensitivity    <= pwdata[CfgW-1:0];
        RegThr:  move_threshold <= pwdata[CfgW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      RegSens: prdata = {24'd0, sensitivity};
      RegThr:  prdata = {24'd0, move_threshold};
      default: prdata = 32'd0;
    endcase
  end

endmodule

`default_nettype wire

// ----- rtl/tgme_scale.sv -----
// Input register stage: takes a word and registers motion times gain.
// Depends on tgme_pkg.
`default_nettype none

module tgme_scale
  import tgme_pkg::*;
(
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            in_valid,
  output logic                 in_ready,
  input  wire logic            command,
  input  wire logic [1:0]      gesture,
  input  wire logic [2:0]      fingers,
  input  wire logic [RelW-1:0] rel_x,
  input  wire logic [RelW-1:0] rel_y,
  input  wire logic [CfgW-1:0] sensitivity,
  input  wire logic            advance,   // downstream takes the held word
  output logic                 held_valid,
  output scaled_t              held
);

  logic signed [CfgW:0]    gain;
  logic signed [ProdW-1:0] px_next;
  logic signed [ProdW-1:0] py_next;
  logic                    take;

  assign gain     = $signed({1'b0, sensitivity});
  assign px_next  = ProdW'($signed(rel_x) * gain);
  assign py_next  = ProdW'($signed(rel_y) * gain);
  assign in_ready = !held_valid || advance;
  assign take     = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (take) begin
      held_valid <= 1'b1;
    end else if (advance) begin
      held_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      held.command <= command;
      held.gesture <= gesture;
      held.motion  <= (fingers == 3'd1) && ((rel_x != '0) || (rel_y != '0));
      held.px      <= px_next;
      held.py      <= py_next;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/tgme_core.sv -----
// Gesture and drag state, motion accumulators, event list for one word.
// Depends on tgme_pkg.
`default_nettype none

module tgme_core
  import tgme_pkg::*;
(
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            fire,
  input  wire scaled_t         item,
  input  wire logic [CfgW-1:0] move_threshold,
  output ev_group_t            grp
);

  logic                  dragging, dragging_next;
  logic                  press_sent, press_sent_next;
  logic signed [AccW-1:0] accum_x, accum_x_next;
  logic signed [AccW-1:0] accum_y, accum_y_next;

  logic signed [AccW:0]   sum_x, sum_y;
  logic signed [AccW-1:0] sat_x, sat_y;
  logic        [AccW-1:0] mag_x, mag_y;
  logic        [AccW-1:0] limit;
  logic                   hit;
  logic signed [AccW-FracW-1:0] whole_x, whole_y;
  logic signed [RelW-1:0] wx, wy;
  logic signed [AccW-1:0] rem_x, rem_y;
  logic                   drag_t;

  function automatic logic signed [AccW-1:0] sat_acc(input logic signed [AccW:0] v);
    if (v[AccW] != v[AccW-1])
      sat_acc = v[AccW] ? {1'b1, {(AccW-1){1'b0}}} : {1'b0, {(AccW-1){1'b1}}};
    else
      sat_acc = v[AccW-1:0];
  endfunction

  // truncate toward zero to whole counts
  function automatic logic signed [AccW-FracW-1:0] to_whole(input logic signed [AccW-1:0] a);
    logic signed [AccW-1:0] b;
    b = a[AccW-1] ? a + AccW'(127) : a;
    to_whole = b[AccW-1:FracW];
  endfunction

  function automatic logic signed [RelW-1:0] clamp16(input logic signed [AccW-FracW-1:0] w);
    if (w > $signed((AccW-FracW)'(32767)))
      clamp16 = 16'sh7fff;
    else if (w < -$signed((AccW-FracW)'(32768)))
      clamp16 = 16'sh8000;
    else
      clamp16 = w[RelW-1:0];
  endfunction

  assign sum_x = {accum_x[AccW-1], accum_x} + (AccW+1)'(item.px);
  assign sum_y = {accum_y[AccW-1], accum_y} + (AccW+1)'(item.py);
  assign sat_x = sat_acc(sum_x);
  assign sat_y = sat_acc(sum_y);
  assign mag_x = sat_x[AccW-1] ? AccW'(-sat_x) : AccW'(sat_x);
  assign mag_y = sat_y[AccW-1] ? AccW'(-sat_y) : AccW'(sat_y);
  assign limit = {{(AccW-CfgW-FracW){1'b0}}, move_threshold, {FracW{1'b0}}};
  assign hit   = (mag_x >= limit) || (mag_y >= limit);

  assign whole_x = to_whole(sat_x);
  assign whole_y = to_whole(sat_y);
  assign wx      = clamp16(whole_x);
  assign wy      = clamp16(whole_y);
  // residue stays in range: no saturation needed here
  assign rem_x   = sat_x - {{(AccW-RelW-FracW){wx[RelW-1]}}, wx, {FracW{1'b0}}};
  assign rem_y   = sat_y - {{(AccW-RelW-FracW){wy[RelW-1]}}, wy, {FracW{1'b0}}};

  always_comb begin
    grp             = '0;
    dragging_next   = dragging;
    press_sent_next = press_sent;
    accum_x_next    = accum_x;
    accum_y_next    = accum_y;
    drag_t          = dragging;
    if (item.command == CmdLift) begin
      if (dragging && press_sent) begin
        grp.kind[0] = EV_RELEASE;
        grp.cnt     = 2'd1;
      end
      dragging_next   = 1'b0;
      press_sent_next = 1'b0;
      accum_x_next    = '0;
      accum_y_next    = '0;
    end else begin
      case (item.gesture)
        GestTap: begin
          if (dragging && !press_sent) drag_t = 1'b0;   // stale drag
          if (!drag_t) begin
            grp.kind[0] = EV_PRESS;
            grp.kind[1] = EV_RELEASE;
            grp.cnt     = 2'd2;
          end
        end
        GestHold: begin
          if (!dragging) begin
            grp.kind[0]     = EV_PRESS;
            grp.cnt         = 2'd1;
            drag_t          = 1'b1;
            press_sent_next = 1'b1;
          end
        end
        default: ;
      endcase
      dragging_next = drag_t;
      if (item.motion) begin
        accum_x_next = sat_x;
        accum_y_next = sat_y;
        if (hit) begin
          grp.kind[grp.cnt] = EV_MOVE;
          grp.cnt           = grp.cnt + 2'd1;
          grp.mx            = wx;
          grp.my            = wy;
          accum_x_next      = rem_x;
          accum_y_next      = rem_y;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dragging   <= 1'b0;
      press_sent <= 1'b0;
      accum_x    <= '0;
      accum_y    <= '0;
    end else if (fire) begin
      dragging   <= dragging_next;
      press_sent <= press_sent_next;
      accum_x    <= accum_x_next;
      accum_y    <= accum_y_next;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/tgme_emit.sv -----
// Result register: holds one word's events and hands them out one a cycle while out_ready is high.
// Depends on tgme_pkg.
`default_nettype none

module tgme_emit
  import tgme_pkg::*;
(
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            load,      // a group is offered and may be taken
  input  wire ev_group_t       grp,
  output logic                 can_load,
  output logic                 out_valid,
  input  wire logic            out_ready,
  output ev_kind_t             out_kind,
  output logic [RelW-1:0]      out_mx,
  output logic [RelW-1:0]      out_my,
  output logic                 out_last
);

  ev_group_t       held;
  logic [CntW-1:0] pos;
  logic            taken;

  assign out_last  = (pos == held.cnt - 2'd1);
  assign taken     = out_valid && out_ready;
  assign can_load  = !out_valid || (taken && out_last);
  assign out_kind  = held.kind[pos];
  assign out_mx    = (out_kind == EV_MOVE) ? held.mx : '0;
  assign out_my    = (out_kind == EV_MOVE) ? held.my : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      pos       <= '0;
    end else if (load) begin
      out_valid <= (grp.cnt != '0);
      pos       <= '0;
    end else if (taken) begin
      if (out_last) begin
        out_valid <= 1'b0;
      end else begin
        pos <= pos + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      held <= grp;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/touch_gesture_to_mouse_events_unit.sv -----
// Touch gesture to mouse event unit, top level.
// Path: a word accepted into the input register (tgme_scale) passes the core into the result register (tgme_emit).
// Throughput: one word per cycle while m_tready is high, when it causes at most one event; a word
// causing more holds the result register until taken (one event per cycle while ready, up to three).
// Reset (rst, synchronous): clears drag state, accumulators and valid flags, sets sensitivity 128, threshold 1.
// Depends on tgme_pkg, tgme_cfg, tgme_scale, tgme_core, tgme_emit.
`default_nettype none

module touch_gesture_to_mouse_events_unit
  import tgme_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  // slave side
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [39:0] s_tdata,   // gesture[1:0], fingers[4:2], rel_x[20:5], rel_y[36:21]
  input  wire logic        s_tuser,   // command
  // master side
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [31:0]      m_tdata,   // move_x[15:0], move_y[31:16]
  output logic [1:0]       m_tuser,   // event_kind
  output logic             m_tlast,
  // configuration
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready
);

  logic [CfgW-1:0] sensitivity;
  logic [CfgW-1:0] move_threshold;
  logic            held_valid;
  scaled_t         held;
  logic            can_load;
  logic            fire;
  ev_group_t       grp;
  ev_kind_t        out_kind;
  logic [RelW-1:0] out_mx;
  logic [RelW-1:0] out_my;

  assign fire = held_valid && can_load;

  tgme_cfg u_cfg (
    .clk            (clk),
    .rst            (rst),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .sensitivity    (sensitivity),
    .move_threshold (move_threshold)
  );

  tgme_scale u_scale (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (s_tvalid),
    .in_ready     (s_tready),
    .command      (s_tuser),
    .gesture      (s_tdata[1:0]),
    .fingers      (s_tdata[4:2]),
    .rel_x        (s_tdata[20:5]),
    .rel_y        (s_tdata[36:21]),
    .sensitivity  (sensitivity),
    .advance      (can_load),
    .held_valid   (held_valid),
    .held         (held)
  );

  tgme_core u_core (
    .clk            (clk),
    .rst            (rst),
    .fire           (fire),
    .item           (held),
    .move_threshold (move_threshold),
    .grp            (grp)
  );

  tgme_emit u_emit (
    .clk       (clk),
    .rst       (rst),
    .load      (fire),
    .grp       (grp),
    .can_load  (can_load),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_kind  (out_kind),
    .out_mx    (out_mx),
    .out_my    (out_my),
    .out_last  (m_tlast)
  );

  assign m_tuser = out_kind;
  assign m_tdata = {out_my, out_mx};

endmodule

`default_nettype wire

// ----- sim/tgme_event_checker.sv -----
// Checker for the touch gesture to mouse event unit: watches the report, event and
// register ports, predicts the mouse events of each accepted report and compares them.
// Depends on tgme_pkg.
`timescale 1ns / 1ps

module tgme_event_checker
  import tgme_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  input  wire logic        s_tready,
  input  wire logic [39:0] s_tdata,   // gesture[1:0], fingers[4:2], rel_x[20:5], rel_y[36:21]
  input  wire logic        s_tuser,   // command
  input  wire logic        m_tvalid,
  input  wire logic        m_tready,
  input  wire logic [31:0] m_tdata,   // move_x[15:0], move_y[31:16]
  input  wire logic [1:0]  m_tuser,   // event_kind
  input  wire logic        m_tlast,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  input  wire logic        pready,
  output int               mismatches,
  output int               pending,
  output int               reports_seen,
  output int               events_seen
);

  typedef struct {
    ev_kind_t               kind;
    logic signed [RelW-1:0] mx;
    logic signed [RelW-1:0] my;
    logic                   last;
  } mouse_event_t;

  localparam int AccMax = (1 << (AccW - 1)) - 1;
  localparam int AccMin = -(1 << (AccW - 1));
  localparam int OneCount = 1 << FracW;

  logic [CfgW-1:0]        sens;
  logic [CfgW-1:0]        thr;
  logic                   dragging;
  logic                   press_sent;
  logic signed [AccW-1:0] acc_x;
  logic signed [AccW-1:0] acc_y;
  mouse_event_t           expected_events[$];

  function automatic int sat_acc(input int v);
    if (v > AccMax) return AccMax;
    if (v < AccMin) return AccMin;
    return v;
  endfunction

  // truncate toward zero to whole counts, clamp to the 16-bit move range
  function automatic int whole_counts(input int v);
    int w;
    w = v / OneCount;
    if (w > 32767) return 32767;
    if (w < -32768) return -32768;
    return w;
  endfunction

  function automatic mouse_event_t make_event(input ev_kind_t kind,
                                              input logic signed [RelW-1:0] mx,
                                              input logic signed [RelW-1:0] my);
    mouse_event_t e;
    e.kind = kind;
    e.mx   = mx;
    e.my   = my;
    e.last = 1'b0;
    return e;
  endfunction

  task automatic report_mismatch(input string what);
    mismatches++;
    if (mismatches <= 30) $display("[%0t] mismatch: %s", $time, what);
  endtask

  task automatic predict_events(input logic cmd, input logic [1:0] gest,
                                input logic [2:0] fingers,
                                input logic signed [RelW-1:0] rx,
                                input logic signed [RelW-1:0] ry);
    mouse_event_t evs[$];
    int sx, sy, limit, wx, wy;
    if (cmd == CmdLift) begin
      if (dragging && press_sent) evs.push_back(make_event(EV_RELEASE, 0, 0));
      dragging   = 1'b0;
      press_sent = 1'b0;
      acc_x      = '0;
      acc_y      = '0;
    end else begin
      if (gest == GestTap) begin
        // a drag flag without its press is stale
        if (dragging && !press_sent) dragging = 1'b0;
        if (!dragging) begin
          evs.push_back(make_event(EV_PRESS, 0, 0));
          evs.push_back(make_event(EV_RELEASE, 0, 0));
        end
      end else if (gest == GestHold) begin
        if (!dragging) begin
          evs.push_back(make_event(EV_PRESS, 0, 0));
          dragging   = 1'b1;
          press_sent = 1'b1;
        end
      end
      if (fingers == 3'd1 && (rx != 0 || ry != 0)) begin
        sx    = sat_acc(int'(acc_x) + int'(rx) * int'(sens));
        sy    = sat_acc(int'(acc_y) + int'(ry) * int'(sens));
        limit = int'(thr) * OneCount;
        if ((sx < 0 ? -sx : sx) >= limit || (sy < 0 ? -sy : sy) >= limit) begin
          wx = whole_counts(sx);
          wy = whole_counts(sy);
          evs.push_back(make_event(EV_MOVE, RelW'(wx), RelW'(wy)));
          sx = sat_acc(sx - wx * OneCount);
          sy = sat_acc(sy - wy * OneCount);
        end
        acc_x = AccW'(sx);
        acc_y = AccW'(sy);
      end
    end
    if (evs.size() > 0) evs[evs.size() - 1].last = 1'b1;
    foreach (evs[i]) expected_events.push_back(evs[i]);
  endtask

  task automatic check_event();
    mouse_event_t           e;
    logic signed [RelW-1:0] got_x;
    logic signed [RelW-1:0] got_y;
    got_x = m_tdata[15:0];
    got_y = m_tdata[31:16];
    events_seen++;
    if (expected_events.size() == 0) begin
      report_mismatch($sformatf("event %0d kind %0d x %0d y %0d last %0b, none expected",
                                events_seen, m_tuser, got_x, got_y, m_tlast));
      return;
    end
    e = expected_events.pop_front();
    if (m_tuser !== e.kind)
      report_mismatch($sformatf("event %0d kind %0d, expected %0d",
                                events_seen, m_tuser, e.kind));
    if (got_x !== e.mx)
      report_mismatch($sformatf("event %0d move_x %0d, expected %0d",
                                events_seen, got_x, e.mx));
    if (got_y !== e.my)
      report_mismatch($sformatf("event %0d move_y %0d, expected %0d",
                                events_seen, got_y, e.my));
    if (m_tlast !== e.last)
      report_mismatch($sformatf("event %0d last %0b, expected %0b",
                                events_seen, m_tlast, e.last));
  endtask

  always @(posedge clk) begin
    if (rst) begin
      sens       = SensReset;
      thr        = ThrReset;
      dragging   = 1'b0;
      press_sent = 1'b0;
      acc_x      = '0;
      acc_y      = '0;
      expected_events.delete();
    end else begin
      if (m_tvalid && m_tready) check_event();
      if (psel && penable && pwrite && pready) begin
        case (paddr[2])
          RegSens: sens = pwdata[CfgW-1:0];
          RegThr:  thr  = pwdata[CfgW-1:0];
          default: ;
        endcase
      end
      if (s_tvalid && s_tready) begin
        reports_seen++;
        predict_events(s_tuser, s_tdata[1:0], s_tdata[4:2], s_tdata[20:5], s_tdata[36:21]);
      end
    end
    pending <= expected_events.size();
  end

endmodule

// ----- sim/touch_gesture_to_mouse_events_unit_tb.sv -----
// Testbench top for the touch gesture to mouse event unit: clock, reset, report stimulus,
// register writes and output back-pressure; checking is done by tgme_event_checker.
// Depends on tgme_pkg, tgme_event_checker and the unit itself.
`timescale 1ns / 1ps

module touch_gesture_to_mouse_events_unit_tb;
  import tgme_pkg::*;

  typedef struct packed {
    logic                   command;
    logic [1:0]             gesture;
    logic [2:0]             fingers;
    logic signed [RelW-1:0] rel_x;
    logic signed [RelW-1:0] rel_y;
  } report_t;

  logic        clk = 1'b0;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [39:0] s_tdata;   // gesture[1:0], fingers[4:2], rel_x[20:5], rel_y[36:21]
  logic        s_tuser;   // command
  logic        m_tvalid;
  logic        m_tready;
  logic [31:0] m_tdata;   // move_x[15:0], move_y[31:16]
  logic [1:0]  m_tuser;   // event_kind
  logic        m_tlast;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  int   mismatches;
  int   pending;
  int   reports_seen;
  int   events_seen;
  int   settings_used = 1;
  int   hold_seq = 0;
  logic stall_mode;
  logic dense;

  always #10 clk = ~clk;

  touch_gesture_to_mouse_events_unit dut (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .s_tuser (s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tuser (m_tuser),
    .m_tlast (m_tlast),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  tgme_event_checker u_checker (
    .clk         (clk),
    .rst         (rst),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .s_tuser     (s_tuser),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .m_tuser     (m_tuser),
    .m_tlast     (m_tlast),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .pready      (pready),
    .mismatches  (mismatches),
    .pending     (pending),
    .reports_seen(reports_seen),
    .events_seen (events_seen)
  );

  function automatic report_t report_of(input logic cmd, input logic [1:0] gest,
                                        input logic [2:0] fingers,
                                        input logic signed [RelW-1:0] rx,
                                        input logic signed [RelW-1:0] ry);
    report_t r;
    r.command = cmd;
    r.gesture = gest;
    r.fingers = fingers;
    r.rel_x   = rx;
    r.rel_y   = ry;
    return r;
  endfunction

  task automatic send_report(input report_t r);
    s_tvalid <= 1'b1;
    s_tuser  <= r.command;
    s_tdata  <= {3'b000, r.rel_y, r.rel_x, r.fingers, r.gesture};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  task automatic idle_gap(input int n);
    s_tvalid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  // stop sending, drain every expected event, then give the pipeline time to empty
  task automatic settle();
    idle_gap(1);
    while (pending != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [CfgW-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {24'($urandom), value};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic apply_setting(input logic [CfgW-1:0] sens, input logic [CfgW-1:0] thr);
    write_reg(RegSens, sens);
    write_reg(RegThr, thr);
    settings_used++;
  endtask

  task automatic send_random_batch(input int n);
    report_t r;
    int      burst_left;
    int      gap;
    int      pick;
    burst_left = $urandom_range(1, 8);
    repeat (n) begin
      r.command = ($urandom_range(0, 9) == 0) ? CmdLift : CmdReport;
      pick = $urandom_range(0, 9);
      if (pick < 5)      r.gesture = GestNone;
      else if (pick < 7) r.gesture = GestTap;
      else if (pick < 9) r.gesture = GestHold;
      else               r.gesture = GestOther;
      r.fingers = ($urandom_range(0, 3) != 0) ? 3'd1 : 3'($urandom_range(0, 7));
      case ($urandom_range(0, 3))
        0: begin
          r.rel_x = RelW'($urandom);
          r.rel_y = RelW'($urandom);
        end
        1: begin
          r.rel_x = '0;
          r.rel_y = ($urandom_range(0, 1) != 0) ? RelW'(int'($urandom_range(0, 40)) - 20) : '0;
        end
        default: begin
          r.rel_x = RelW'(int'($urandom_range(0, 400)) - 200);
          r.rel_y = RelW'(int'($urandom_range(0, 400)) - 200);
        end
      endcase
      send_report(r);
      burst_left--;
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 8);
        gap = dense ? 0 : $urandom_range(0, 6);
        if (gap > 0) idle_gap(gap);
      end
    end
  endtask

  // output side: always ready or a random ready pattern, plus a long hold-off on request
  initial begin : sink
    int   hold_seen;
    int   hold_left;
    int   run_left;
    logic run_ready;
    hold_seen = 0;
    hold_left = 0;
    run_left  = 0;
    run_ready = 1'b1;
    m_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_seq != hold_seen) begin
        hold_seen = hold_seq;
        hold_left = 150;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else if (!stall_mode) begin
        m_tready <= 1'b1;
      end else begin
        if (run_left == 0) begin
          run_ready = ($urandom_range(0, 2) != 0);
          run_left  = run_ready ? $urandom_range(1, 8) : $urandom_range(1, 5);
        end
        run_left--;
        m_tready <= run_ready;
      end
    end
  end

  initial begin : stimulus
    rst        <= 1'b1;
    s_tvalid   <= 1'b0;
    s_tdata    <= '0;
    s_tuser    <= 1'b0;
    psel       <= 1'b0;
    penable    <= 1'b0;
    pwrite     <= 1'b0;
    paddr      <= '0;
    pwdata     <= '0;
    stall_mode <= 1'b1;
    dense = 1'b0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset gain and threshold: taps, drags, lifts, field extremes
    send_report(report_of(CmdReport, GestTap, 3'd0, 16'sd0, 16'sd0));
    send_report(report_of(CmdReport, GestHold, 3'd1, 16'sd5, -16'sd3));
    send_report(report_of(CmdReport, GestTap, 3'd2, 16'sd100, 16'sd100));
    idle_gap(3);
    send_report(report_of(CmdReport, GestOther, 3'd1, 16'sd0, 16'sd0));
    send_report(report_of(CmdLift, GestTap, 3'd1, 16'sd7, 16'sd7));
    send_report(report_of(CmdLift, GestNone, 3'd0, 16'sd0, 16'sd0));
    send_report(report_of(CmdReport, GestTap, 3'd1, -16'sd1, 16'sd2));
    send_report(report_of(CmdReport, GestNone, 3'd1, 16'sh7fff, 16'sh8000));
    idle_gap(2);
    send_report(report_of(CmdReport, GestNone, 3'd5, 16'sh8000, 16'sh7fff));
    send_report(report_of(CmdReport, GestHold, 3'd7, 16'sd1, 16'sd1));
    send_report(report_of(CmdReport, GestHold, 3'd1, 16'sd0, 16'sd0));
    send_report(report_of(CmdLift, GestOther, 3'd7, -16'sd1, -16'sd1));
    settle();

    // full gain and threshold: moves clamp to 16 bits, accumulators saturate
    apply_setting(8'd255, 8'd255);
    repeat (8) send_report(report_of(CmdReport, GestNone, 3'd1, 16'sh7fff, 16'sh8000));
    send_report(report_of(CmdLift, GestNone, 3'd1, 16'sd0, 16'sd0));
    settle();

    // zero gain: motion never accumulates
    apply_setting(8'd0, 8'd1);
    send_report(report_of(CmdReport, GestNone, 3'd1, 16'sh7fff, 16'sd1));
    settle();

    // zero threshold: any motion gives a move, here of zero counts
    apply_setting(8'd1, 8'd0);
    send_report(report_of(CmdReport, GestNone, 3'd1, 16'sd1, 16'sd0));
    send_report(report_of(CmdReport, GestNone, 3'd1, 16'sd0, -16'sd1));
    send_report(report_of(CmdLift, GestNone, 3'd0, 16'sd0, 16'sd0));
    settle();

    // random reports; first phase without any idling on either side
    apply_setting(8'd128, 8'd1);
    stall_mode <= 1'b0;
    dense = 1'b1;
    send_random_batch(32);
    settle();

    apply_setting(8'd255, 8'd255);
    stall_mode <= 1'b1;
    dense = 1'b0;
    send_random_batch(32);
    settle();

    // long output hold-off while reports keep coming
    apply_setting(8'($urandom_range(0, 255)), 8'($urandom_range(1, 16)));
    hold_seq <= hold_seq + 1;
    dense = 1'b1;
    send_random_batch(32);
    settle();

    apply_setting(8'd1, 8'd1);
    dense = 1'b0;
    send_random_batch(32);
    settle();

    apply_setting(8'($urandom_range(0, 255)), 8'($urandom_range(1, 255)));
    send_random_batch(32);
    settle();
    repeat (10) @(posedge clk);

    $display("Run covered %0d touch reports and %0d mouse events over %0d gain/threshold settings,",
             reports_seen, events_seen, settings_used);
    $display("with taps, drags, lifts, clamped and saturated motion, and output back-pressure.");
    if (mismatches == 0 && pending == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // watchdog, far beyond the slowest legal run
  initial begin : watchdog
    #4_000_000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule
